// ----- design/ppe_pkg.sv -----
// Shared types, constants and helpers for the particle pool update core.
// No dependencies; imported by the core module and the divider.
package ppe_pkg;

  localparam int POOL_SIZE = 64;
  localparam int SLOT_W    = $clog2(POOL_SIZE);
  localparam int OUT_SLOT_W = 6;

  // request function codes
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_EMIT   = 2'd1;
  localparam logic [1:0] FUNC_RENDER = 2'd2;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROT_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_BEG = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_END = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE_VAR  = 3'd4;

  // blend factor is unsigned Q1.16 so that 1.0 is included
  localparam int T_W = 17;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] life_left;
    logic [30:0]        life_total;
    logic [23:0]        start_size;
    logic [23:0]        final_size;
    logic signed [31:0] spin;
  } ent_t;

  localparam int ENT_W = $bits(ent_t);

  function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
    logic signed [31:0] r;
    if (v > 35'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // one color channel: (lo*(1-t) + hi*t + half) >> 16
  function automatic logic [7:0] blend8(input logic [7:0] lo, input logic [7:0] hi,
                                        input logic [T_W-1:0] t);
    logic [T_W-1:0] tc;
    logic [26:0]    acc;
    tc  = T_ONE - t;
    acc = 27'(lo * tc) + 27'(hi * t) + 27'd32768;
    return acc[23:16];
  endfunction

endpackage

// ----- design/particle_pool_euler_update_core.sv -----
// Particle pool with Euler integration: emit, tick and render requests.
// Depends on ppe_pkg, ppe_ram (slot state) and ppe_div (blend factor).
//
//  channel | signals                         | direction | notes
//  --------+---------------------------------+-----------+------------------------
//  in      | in_valid/in_ready, in_* fields  | input     | one request per accept
//  out     | out_valid/out_ready, out_*      | output    | render results only
//  cfg     | cfg_valid/cfg_ready, index/data | input     | always ready
//
// Emit steps through states E1, E2 and E3. Tick skips inactive slots, retires
// expired ones and updates live ones with four products in turn on the shared
// 32x17 multiplier and a read-modify-write of the single slot RAM. Render skips
// inactive slots and runs the serial divider for active slots with life left.
// Reset clears the active flags, sets the emit pointer and loads config defaults.
// A render stalls on its output register while it is full and out_ready is low.
module particle_pool_euler_update_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic signed [31:0]            in_pos_x,
  input  logic signed [31:0]            in_pos_y,
  input  logic signed [31:0]            in_pos_z,
  input  logic signed [31:0]            in_vel_x,
  input  logic signed [31:0]            in_vel_y,
  input  logic signed [31:0]            in_vel_z,
  input  logic [30:0]                   in_life_time,
  input  logic [23:0]                   in_size_begin,
  input  logic [23:0]                   in_size_end,
  input  logic [15:0]                   in_random_fraction,
  input  logic [15:0]                   in_time_step,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            out_x,
  output logic signed [31:0]            out_y,
  output logic signed [31:0]            out_z,
  output logic [23:0]                   out_size,
  output logic signed [31:0]            out_angle,
  output logic [31:0]                   out_color,
  output logic [ppe_pkg::OUT_SLOT_W-1:0] out_slot,
  output logic                          out_last,
  output logic                          out_empty_res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ppe_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import ppe_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_E1    = 5'd1;
  localparam logic [4:0] S_E2    = 5'd2;
  localparam logic [4:0] S_E3    = 5'd3;
  localparam logic [4:0] S_TSCAN = 5'd4;
  localparam logic [4:0] S_TLAT  = 5'd5;
  localparam logic [4:0] S_TM0   = 5'd6;
  localparam logic [4:0] S_TM1   = 5'd7;
  localparam logic [4:0] S_TM2   = 5'd8;
  localparam logic [4:0] S_TM3   = 5'd9;
  localparam logic [4:0] S_TM4   = 5'd10;
  localparam logic [4:0] S_TWR   = 5'd11;
  localparam logic [4:0] S_RSCAN = 5'd12;
  localparam logic [4:0] S_RLAT  = 5'd13;
  localparam logic [4:0] S_RDIV  = 5'd14;
  localparam logic [4:0] S_RM0   = 5'd15;
  localparam logic [4:0] S_RM1   = 5'd16;
  localparam logic [4:0] S_RM2   = 5'd17;
  localparam logic [4:0] S_RM3   = 5'd18;
  localparam logic [4:0] S_ROUT  = 5'd19;
  localparam logic [4:0] S_REMPTY = 5'd20;

  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(POOL_SIZE - 1);

  // configuration
  logic signed [31:0] gravity_r;
  logic [15:0]        rot_step_r;
  logic [31:0]        color_beg_r;
  logic [31:0]        color_end_r;
  logic [19:0]        size_var_r;

  logic [4:0]          state_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [SLOT_W-1:0]   emit_slot_r;
  logic [POOL_SIZE-1:0] active_r;

  // captured request payload
  ent_t               emit_r;
  logic [15:0]        rf_r;
  logic [15:0]        dt_r;
  logic [35:0]        var_prod_r;
  logic [44:0]        size_prod_r;

  ent_t               ent_r;
  logic signed [48:0] prod_r;
  logic signed [59:0] ang_r;
  logic [41:0]        sz_acc_r;
  logic [T_W-1:0]     t_r;
  logic [31:0]        col_r;

  // output register
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r, out_angle_r;
  logic [23:0]        out_size_r;
  logic [31:0]        out_color_r;
  logic [OUT_SLOT_W-1:0] out_slot_r;
  logic               out_last_r, out_empty_r;

  // RAM and divider
  logic               ram_we;
  logic [SLOT_W-1:0]  ram_waddr;
  ent_t               ram_wdata;
  ent_t               ram_rdata;
  logic               div_start;
  logic               div_done;
  logic [T_W-1:0]     div_quo;

  logic               in_acc;
  logic               out_free;
  logic [20:0]        size_fac;
  logic [28:0]        size_sh;
  logic [T_W-1:0]     tc;
  logic [POOL_SIZE-1:0] above_mask;
  logic               last_slot;
  logic signed [31:0] mul_a;
  logic signed [59:0] ang_rnd;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || out_ready;

  assign size_fac   = 21'h10000 + 21'(var_prod_r[35:16]);
  assign size_sh    = size_prod_r[44:16];
  assign tc         = T_ONE - t_r;
  assign above_mask = ({POOL_SIZE{1'b1}} << slot_r) << 1;
  assign last_slot  = ~|(active_r & above_mask);
  assign ang_rnd    = ang_r + 60'sh0_8000_0000;

  always_comb begin
    case (state_r)
      S_TM0:   mul_a = gravity_r;
      S_TM1:   mul_a = ent_r.vx;
      S_TM2:   mul_a = ent_r.vy;
      S_TM3:   mul_a = ent_r.vz;
      default: mul_a = '0;
    endcase
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_r;
    ram_wdata = ent_r;
    if (state_r == S_E3) begin
      ram_we     = 1'b1;
      ram_waddr  = emit_slot_r;
      ram_wdata  = emit_r;
      ram_wdata.start_size = (size_sh > 29'hFF_FFFF) ? 24'hFF_FFFF : size_sh[23:0];
    end else if (state_r == S_TWR) begin
      ram_we = 1'b1;
    end
  end

  assign div_start = (state_r == S_RLAT) && (ram_rdata.life_left > 0)
                     && (ram_rdata.life_total != '0);

  ppe_ram #(.WIDTH(ENT_W), .DEPTH(POOL_SIZE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_r),
    .rdata (ram_rdata)
  );

  ppe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (ram_rdata.life_left[30:0]),
    .den   (ram_rdata.life_total),
    .done  (div_done),
    .quo   (div_quo)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gravity_r   <= -32'sd642908;
      rot_step_r  <= 16'd655;
      color_beg_r <= 32'hFFFF_FFFF;
      color_end_r <= 32'h0;
      size_var_r  <= 20'h0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_GRAVITY:   gravity_r   <= cfg_data;
        CFG_ROT_STEP:  rot_step_r  <= cfg_data[15:0];
        CFG_COLOR_BEG: color_beg_r <= cfg_data;
        CFG_COLOR_END: color_end_r <= cfg_data;
        CFG_SIZE_VAR:  size_var_r  <= cfg_data[19:0];
        default: ;
      endcase
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      emit_slot_r <= SLOT_LAST;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (((state_r == S_ROUT) || (state_r == S_REMPTY)) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          slot_r <= '0;
          if (in_acc) begin
            case (in_func)
              FUNC_TICK:   state_r <= S_TSCAN;
              FUNC_EMIT:   state_r <= S_E1;
              FUNC_RENDER: state_r <= (active_r == '0) ? S_REMPTY : S_RSCAN;
              default:     state_r <= S_IDLE;
            endcase
          end
        end
        S_E1: state_r <= S_E2;
        S_E2: state_r <= S_E3;
        S_E3: begin
          active_r[emit_slot_r] <= 1'b1;
          emit_slot_r <= (emit_slot_r == '0) ? SLOT_LAST : emit_slot_r - 1'b1;
          state_r     <= S_IDLE;
        end
        S_TSCAN: begin
          if (active_r[slot_r]) begin
            state_r <= S_TLAT;
          end else if (slot_r == SLOT_LAST) begin
            state_r <= S_IDLE;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_TLAT: begin
          if (ram_rdata.life_left <= 0) begin
            // retire, then advance
            active_r[slot_r] <= 1'b0;
            if (slot_r == SLOT_LAST) begin
              state_r <= S_IDLE;
            end else begin
              slot_r  <= slot_r + 1'b1;
              state_r <= S_TSCAN;
            end
          end else begin
            state_r <= S_TM0;
          end
        end
        S_TM0: state_r <= S_TM1;
        S_TM1: state_r <= S_TM2;
        S_TM2: state_r <= S_TM3;
        S_TM3: state_r <= S_TM4;
        S_TM4: state_r <= S_TWR;
        S_TWR: begin
          if (slot_r == SLOT_LAST) begin
            state_r <= S_IDLE;
          end else begin
            slot_r  <= slot_r + 1'b1;
            state_r <= S_TSCAN;
          end
        end
        S_RSCAN: begin
          if (active_r[slot_r]) begin
            state_r <= S_RLAT;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
        end
        S_RLAT: state_r <= div_start ? S_RDIV : S_RM0;
        S_RDIV: begin
          if (div_done) begin
            state_r <= S_RM0;
          end
        end
        S_RM0: state_r <= S_RM1;
        S_RM1: state_r <= S_RM2;
        S_RM2: state_r <= S_RM3;
        S_RM3: state_r <= S_ROUT;
        S_ROUT: begin
          if (out_free) begin
            if (last_slot) begin
              state_r <= S_IDLE;
            end else begin
              slot_r  <= slot_r + 1'b1;
              state_r <= S_RSCAN;
            end
          end
        end
        S_REMPTY: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      emit_r.px         <= in_pos_x;
      emit_r.py         <= in_pos_y;
      emit_r.pz         <= in_pos_z;
      emit_r.vx         <= in_vel_x;
      emit_r.vy         <= in_vel_y;
      emit_r.vz         <= in_vel_z;
      emit_r.life_total <= in_life_time;
      emit_r.life_left  <= {1'b0, in_life_time};
      emit_r.start_size <= in_size_begin;
      emit_r.final_size <= in_size_end;
      emit_r.spin       <= '0;
      rf_r              <= in_random_fraction;
      dt_r              <= in_time_step;
    end
    case (state_r)
      S_E1: var_prod_r  <= size_var_r * rf_r;
      S_E2: size_prod_r <= 45'(emit_r.start_size * size_fac);
      S_TLAT, S_RLAT: begin
        ent_r <= ram_rdata;
        t_r   <= '0;
      end
      S_RDIV: t_r <= div_quo;
      S_RM0: ang_r    <= ent_r.spin * $signed({1'b0, DEG2RAD_Q32});
      S_RM1: sz_acc_r <= 42'(ent_r.final_size * tc);
      S_RM2: sz_acc_r <= sz_acc_r + 42'(ent_r.start_size * t_r) + 42'd32768;
      S_RM3: begin
        col_r <= {blend8(color_end_r[31:24], color_beg_r[31:24], t_r),
                  blend8(color_end_r[23:16], color_beg_r[23:16], t_r),
                  blend8(color_end_r[15:8],  color_beg_r[15:8],  t_r),
                  blend8(color_end_r[7:0],   color_beg_r[7:0],   t_r)};
      end
      default: ;
    endcase
    case (state_r)
      S_TM0, S_TM1, S_TM2, S_TM3: prod_r <= mul_a * $signed({1'b0, dt_r});
      default: ;
    endcase
    // each step consumes the product from the step before
    case (state_r)
      S_TM1: ent_r.vy <= sat32(35'(ent_r.vy) + 35'(prod_r >>> 16));
      S_TM2: ent_r.px <= sat32(35'(ent_r.px) + 35'(prod_r >>> 16));
      S_TM3: ent_r.py <= sat32(35'(ent_r.py) + 35'(prod_r >>> 16));
      S_TM4: begin
        ent_r.pz        <= sat32(35'(ent_r.pz) + 35'(prod_r >>> 16));
        ent_r.life_left <= sat32(35'(ent_r.life_left) - 35'($signed({1'b0, dt_r})));
        ent_r.spin      <= sat32(35'(ent_r.spin) + 35'($signed({1'b0, rot_step_r})));
      end
      default: ;
    endcase
    if (state_r == S_ROUT && out_free) begin
      out_x_r     <= ent_r.px;
      out_y_r     <= ent_r.py;
      out_z_r     <= ent_r.pz;
      out_size_r  <= sz_acc_r[39:16];
      out_angle_r <= {{4{ang_rnd[59]}}, ang_rnd[59:32]};
      out_color_r <= col_r;
      out_slot_r  <= OUT_SLOT_W'(slot_r);
      out_last_r  <= last_slot;
      out_empty_r <= 1'b0;
    end else if (state_r == S_REMPTY && out_free) begin
      out_x_r     <= '0;
      out_y_r     <= '0;
      out_z_r     <= '0;
      out_size_r  <= '0;
      out_angle_r <= '0;
      out_color_r <= '0;
      out_slot_r  <= '0;
      out_last_r  <= 1'b1;
      out_empty_r <= 1'b1;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x         = out_x_r;
  assign out_y         = out_y_r;
  assign out_z         = out_z_r;
  assign out_size      = out_size_r;
  assign out_angle     = out_angle_r;
  assign out_color     = out_color_r;
  assign out_slot      = out_slot_r;
  assign out_last      = out_last_r;
  assign out_empty_res = out_empty_r;

endmodule

// ----- design/ppe_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module ppe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/ppe_div.sv -----
// Restoring divider for the render blend factor t = floor(left*2^16/total).
// Depends on ppe_pkg; one quotient bit per cycle, requires left <= total.
module ppe_div (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [30:0]           num,
  input  logic [30:0]           den,
  output logic                  done,
  output logic [ppe_pkg::T_W-1:0] quo
);
  import ppe_pkg::*;

  logic                      busy_r;
  logic                      done_r;
  logic                      first_r;
  logic [$clog2(T_W)-1:0]    cnt_r;
  logic [31:0]               rem_r;
  logic [30:0]               den_r;
  logic [T_W-1:0]            quo_r;
  logic [31:0]               trial;
  logic                      fits;

  assign trial = first_r ? rem_r : {rem_r[30:0], 1'b0};
  assign fits  = trial >= {1'b0, den_r};
  assign done  = done_r;
  assign quo   = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= {1'b0, num};
      den_r   <= den;
      quo_r   <= '0;
      first_r <= 1'b1;
      cnt_r   <= $clog2(T_W)'(T_W - 1);
    end else if (busy_r) begin
      rem_r   <= fits ? trial - {1'b0, den_r} : trial;
      quo_r   <= {quo_r[T_W-2:0], fits};
      first_r <= 1'b0;
      cnt_r   <= cnt_r - 1'b1;
    end
  end

endmodule
